// File: design/table_driven_comment_extractor_defines.svh
// Assertion macros shared by the comment extractor modules.
`ifndef TABLE_DRIVEN_COMMENT_EXTRACTOR_DEFINES_SVH
`define TABLE_DRIVEN_COMMENT_EXTRACTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising clock edge outside of reset.
`define TDCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TDCE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define TDCE_ASSERT(lbl, prop, msg)
`define TDCE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: design/tdce_pkg.sv
// Package with shared types and constants of the comment extractor.
`timescale 1ns / 1ps

package tdce_pkg;

    localparam int CHAR_W  = 8;
    localparam int STATE_W = 3;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    // Character classes.
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;

    // First state that completes a comment.
    localparam logic [STATE_W-1:0] FIRST_FINAL = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_ON_SLASH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_ON_STAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_ON_OTHER = 2'd2;

    // What an accepted character does to the buffer.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_FINAL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_start;
        logic rd_next;
        logic load_entry;
        logic load_tail;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       fill_zero;
        logic       last_entry;
        logic       out_free;
    } t_dp_sts;

endpackage

// File: design/tdce_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module tdce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/tdce_ctrl.sv
// Controller state machine: accepts characters and sequences the drain of a comment.
`timescale 1ns / 1ps

`include "table_driven_comment_extractor_defines.svh"

module tdce_ctrl
    import tdce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_dp_cmd    cmd;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_sts.kind == KIND_FINAL) begin
                        if (i_sts.fill_zero) begin
                            n_state = ST_TAIL;
                        end else begin
                            cmd.rd_start = 1'b1;
                            n_state      = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    cmd.load_entry = 1'b1;
                    if (i_sts.last_entry) begin
                        n_state = ST_TAIL;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (i_sts.out_free) begin
                    cmd.load_tail = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = cmd;

    // A completing character always leads into the drain.
    `TDCE_ASSERT(a_final_leaves_idle, (cmd.accept && i_sts.kind == KIND_FINAL) |=> (r_state != ST_IDLE), "final character did not start a drain")
    // The buffer is only drained when it holds something.
    `TDCE_ASSERT(a_load_nonempty, (r_state == ST_LOAD) |-> !i_sts.fill_zero, "drain of an empty buffer")
    // A beat is only loaded when the output register can take it.
    `TDCE_ASSERT_ALWAYS(a_load_when_free, (cmd.load_entry || cmd.load_tail) |-> i_sts.out_free, "output beat overwritten")
    // The closing beat returns the block to accepting characters.
    `TDCE_ASSERT(a_tail_to_idle, cmd.load_tail |=> o_in_ready, "block did not return to idle")

endmodule

// File: design/tdce_dp.sv
// Datapath: DFA table lookup, comment buffer, fill count and output register.
`timescale 1ns / 1ps

module tdce_dp
    import tdce_pkg::*;
#(
    parameter int BUFFER_DEPTH = 63,
    parameter int NUM_STATES   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAR_W-1:0]    o_out_char,
    output logic                 o_last_of_comment,
    output logic                 o_truncated
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);
    localparam logic [STATE_W:0] NSTATES = (STATE_W + 1)'(NUM_STATES);

    logic [CFG_W-1:0]   r_next_on_slash;
    logic [CFG_W-1:0]   r_next_on_star;
    logic [CFG_W-1:0]   r_next_on_other;
    logic [STATE_W-1:0] r_fsm;
    logic [FW-1:0]      r_fill;
    logic               r_ovf;
    logic [CHAR_W-1:0]  r_hold;
    logic [AW-1:0]      r_idx;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic               r_out_trunc;

    logic [CFG_W-1:0]   row;
    logic [STATE_W-1:0] nxt_raw;
    logic [STATE_W-1:0] nxt;
    logic [1:0]         kind;
    logic               full;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [CHAR_W-1:0]  rd_data;
    logic               out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_on_slash <= '0;
            r_next_on_star  <= '0;
            r_next_on_other <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NEXT_ON_SLASH: r_next_on_slash <= i_cfg_data;
                REG_NEXT_ON_STAR:  r_next_on_star  <= i_cfg_data;
                REG_NEXT_ON_OTHER: r_next_on_other <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Table lookup for the next DFA state of the incoming character.
    always_comb begin
        if (i_in_char == CHAR_SLASH) begin
            row = r_next_on_slash;
        end else if (i_in_char == CHAR_STAR) begin
            row = r_next_on_star;
        end else begin
            row = r_next_on_other;
        end
        nxt_raw = row[5'(r_fsm) * 5'd3 +: STATE_W];
        nxt     = ({1'b0, nxt_raw} >= NSTATES) ? '0 : nxt_raw;
        if (nxt == '0) begin
            kind = KIND_CLEAR;
        end else if (nxt < FIRST_FINAL) begin
            kind = KIND_APPEND;
        end else begin
            kind = KIND_FINAL;
        end
    end

    assign full     = (r_fill == DEPTH_F);
    assign out_free = !r_out_valid || i_out_ready;
    assign wr_en    = i_cmd.accept && (kind == KIND_APPEND) && !full;
    assign rd_en    = i_cmd.rd_start || i_cmd.rd_next;
    assign rd_addr  = i_cmd.rd_start ? '0 : AW'(r_idx + 1'b1);

    // DFA state, fill count and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm  <= '0;
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.accept) begin
            case (kind)
                KIND_APPEND: begin
                    r_fsm <= nxt;
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                KIND_FINAL: begin
                    r_fsm <= '0;
                end
                default: begin
                    r_fsm  <= '0;
                    r_fill <= '0;
                    r_ovf  <= 1'b0;
                end
            endcase
        end else if (i_cmd.load_tail) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end
    end

    // Completing character and drain index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hold <= i_in_char;
        end
        if (i_cmd.rd_start) begin
            r_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Comment buffer.
    tdce_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_fill)),
        .i_wr_data (i_in_char),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_entry || i_cmd.load_tail) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_entry) begin
            r_out_char  <= rd_data;
            r_out_last  <= 1'b0;
            r_out_trunc <= r_ovf;
        end else if (i_cmd.load_tail) begin
            r_out_char  <= r_hold;
            r_out_last  <= 1'b1;
            r_out_trunc <= r_ovf;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.kind       = kind;
        o_sts.fill_zero  = (r_fill == '0);
        o_sts.last_entry = ((FW'(r_idx) + FW'(1)) == r_fill);
        o_sts.out_free   = out_free;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_char        = r_out_char;
    assign o_last_of_comment = r_out_last;
    assign o_truncated       = r_out_trunc;

endmodule

// File: design/table_driven_comment_extractor.sv
// Top level of the table-driven comment extractor.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready / i_in_char) takes one character per beat.
// - Config channel (i_cfg_valid / o_cfg_ready) writes one of three 24-bit DFA rows:
//   index 0 slash, 1 star, 2 any other character; other indexes are ignored.
//   Bits [3s+2:3s] of a row give the next state from state s. Write only while idle.
// - Output channel (o_out_valid / i_out_ready) gives one comment character per beat,
//   with o_last_of_comment on the closing beat and o_truncated on every beat of a
//   comment that lost characters to a full buffer.
// Throughput: characters that do not complete a comment stream at one per cycle while
// no drain is in progress. A completing character with n buffered characters holds
// the block until its n + 1 beats are loaded: the buffered characters, read in turn
// through the single read port of the comment buffer, then the completing character.
// The first beat is loaded in the LOAD or TAIL state after acceptance, buffer empty or not.
// Reset (synchronous, active low) clears the DFA rows, state, fill count and flag.
// The buffer needs no clearing. When the receiver stalls, the drain pauses and no
// new character is taken until the last beat of the comment is loaded.
`timescale 1ns / 1ps

module table_driven_comment_extractor
    import tdce_pkg::*;
#(
    parameter int BUFFER_DEPTH = 63,
    parameter int NUM_STATES   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAR_W-1:0]    o_out_char,
    output logic                 o_last_of_comment,
    output logic                 o_truncated
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    tdce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tdce_dp #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .NUM_STATES  (NUM_STATES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_in_char         (i_in_char),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_char        (o_out_char),
        .o_last_of_comment (o_last_of_comment),
        .o_truncated       (o_truncated)
    );

endmodule
